// ===== design/hcirx_pkg.sv =====
// Package for the HCI UART (H4) receive deframer with command-credit tracking.
// Holds byte codes, result class codes and the result record type.
// No dependencies.
`default_nettype none

package hcirx_pkg;

	// H4 packet type bytes and credit-bearing event codes
	localparam logic [7:0] CODE_EVENT      = 8'h04;
	localparam logic [7:0] CODE_ACL        = 8'h02;
	localparam logic [7:0] EV_CMD_COMPLETE = 8'h0E;
	localparam logic [7:0] EV_CMD_STATUS   = 8'h0F;

	// Request kind carried on the input tuser
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_CMD  = 1'b1;

	// Byte class codes
	localparam logic [3:0] CLS_TYPE    = 4'd0;
	localparam logic [3:0] CLS_EVCODE  = 4'd1;
	localparam logic [3:0] CLS_EVLEN   = 4'd2;
	localparam logic [3:0] CLS_EVPARAM = 4'd3;
	localparam logic [3:0] CLS_HLO     = 4'd4;
	localparam logic [3:0] CLS_HHI     = 4'd5;
	localparam logic [3:0] CLS_LLO     = 4'd6;
	localparam logic [3:0] CLS_LHI     = 4'd7;
	localparam logic [3:0] CLS_ACLDATA = 4'd8;
	localparam logic [3:0] CLS_NONE    = 4'd9;

	// Packet kind codes
	localparam logic [1:0] KIND_EVENT = 2'd0;
	localparam logic [1:0] KIND_ACL   = 2'd1;
	localparam logic [1:0] KIND_NONE  = 2'd2;

	// Credits after reset
	localparam logic [7:0] CREDITS_RESET = 8'd1;

	// Widths of the output beat
	localparam int TDATA_W = 40;
	localparam int TUSER_W = 6;

	// One result item
	typedef struct packed {
		logic [3:0]  byte_class;
		logic [1:0]  packet_kind;
		logic [7:0]  data_byte;
		logic [15:0] payload_index;
		logic        end_of_packet;
		logic        bad_type;
		logic [7:0]  credits_now;
		logic        command_granted;
	} res_t;

endpackage

`default_nettype wire

// ===== design/hci_uart_rx_deframer_credits_top.sv =====
// Top level of the HCI UART (H4) receive deframer with command-credit tracking.
// Depends on hcirx_pkg for codes and the result record.
//
// A result beat is registered in the output register, or in the one-entry skid
// register while the output stalls. Throughput: one input beat per cycle while
// the skid register is empty, so the input side takes one more beat in a stall.
// Reset (arst_n low, asynchronous): parser waits for a type byte, credits = 1,
// no result pending. A configuration write loads the credit count at once.
`default_nettype none

module hci_uart_rx_deframer_credits_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration: initial_credits
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [7:0]                    cfg_data,
	// input beat
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
	input  wire logic                          s_axis_tuser,  // [0] req_type
	// output beat
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [7:0] data_byte, [23:8] payload_index, [24] bad_type, [32:25] credits_now,
	// [33] command_granted, [39:34] zero
	output logic [hcirx_pkg::TDATA_W-1:0]      m_axis_tdata,
	// [3:0] byte_class, [5:4] packet_kind
	output logic [hcirx_pkg::TUSER_W-1:0]      m_axis_tuser,
	output logic                               m_axis_tlast   // end_of_packet
);
	import hcirx_pkg::*;

	typedef enum logic [2:0] {
		PH_TYPE    = 3'd0,
		PH_EVCODE  = 3'd1,
		PH_EVLEN   = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_HLO     = 3'd4,
		PH_HHI     = 3'd5,
		PH_LLO     = 3'd6,
		PH_LHI     = 3'd7
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        kind_q, kind_d;
	logic [7:0]  evcode_q, evcode_d;
	logic [7:0]  len_lo_q, len_lo_d;
	logic [15:0] remain_q, remain_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  credit_q, credit_d;
	logic [8:0]  pend_q, pend_d;
	logic        finish;
	res_t        res;

	res_t        out_q, skid_q;
	logic        out_valid_q, skid_valid_q;
	logic        in_fire, out_fire;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !skid_valid_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_fire      = m_axis_tvalid && m_axis_tready;

	// Parser and credit logic for the beat at the input
	always_comb begin
		phase_d  = phase_q;
		kind_d   = kind_q;
		evcode_d = evcode_q;
		len_lo_d = len_lo_q;
		remain_d = remain_q;
		count_d  = count_q;
		credit_d = credit_q;
		pend_d   = pend_q;
		finish   = 1'b0;
		res      = '0;
		res.byte_class  = CLS_NONE;
		res.packet_kind = KIND_NONE;
		if (s_axis_tuser == REQ_CMD) begin
			if (credit_q != 8'd0) begin
				credit_d = credit_q - 8'd1;
				res.command_granted = 1'b1;
			end
		end else begin
			res.data_byte = s_axis_tdata;
			unique case (phase_q)
				PH_TYPE: begin
					res.byte_class = CLS_TYPE;
					pend_d = '0;
					if (s_axis_tdata == CODE_EVENT) begin
						kind_d = 1'b0;
						res.packet_kind = KIND_EVENT;
						phase_d = PH_EVCODE;
					end else if (s_axis_tdata == CODE_ACL) begin
						kind_d = 1'b1;
						res.packet_kind = KIND_ACL;
						phase_d = PH_HLO;
					end else begin
						res.bad_type = 1'b1;
					end
				end
				PH_EVCODE: begin
					res.byte_class  = CLS_EVCODE;
					res.packet_kind = KIND_EVENT;
					evcode_d = s_axis_tdata;
					phase_d = PH_EVLEN;
				end
				PH_EVLEN: begin
					res.byte_class  = CLS_EVLEN;
					res.packet_kind = KIND_EVENT;
					remain_d = {8'd0, s_axis_tdata};
					count_d = '0;
					if (s_axis_tdata == 8'd0) begin
						finish = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					res.packet_kind   = kind_q ? KIND_ACL : KIND_EVENT;
					res.byte_class    = kind_q ? CLS_ACLDATA : CLS_EVPARAM;
					res.payload_index = count_q;
					// Credit-bearing events stage their credit value until the packet ends
					if (!kind_q) begin
						if (evcode_q == EV_CMD_COMPLETE && count_q == 16'd0) begin
							pend_d = {1'b1, s_axis_tdata};
						end else if (evcode_q == EV_CMD_STATUS && count_q == 16'd1) begin
							pend_d = {1'b1, s_axis_tdata};
						end
					end
					count_d = count_q + 16'd1;
					if (remain_q <= 16'd1) begin
						remain_d = '0;
						finish = 1'b1;
					end else begin
						remain_d = remain_q - 16'd1;
					end
				end
				PH_HLO: begin
					res.byte_class  = CLS_HLO;
					res.packet_kind = KIND_ACL;
					phase_d = PH_HHI;
				end
				PH_HHI: begin
					res.byte_class  = CLS_HHI;
					res.packet_kind = KIND_ACL;
					phase_d = PH_LLO;
				end
				PH_LLO: begin
					res.byte_class  = CLS_LLO;
					res.packet_kind = KIND_ACL;
					len_lo_d = s_axis_tdata;
					phase_d = PH_LHI;
				end
				PH_LHI: begin
					res.byte_class  = CLS_LHI;
					res.packet_kind = KIND_ACL;
					remain_d = {s_axis_tdata, len_lo_q};
					count_d = '0;
					if ({s_axis_tdata, len_lo_q} == 16'd0) begin
						finish = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			endcase
			// End of packet: apply any staged credit load
			if (finish) begin
				if (pend_d[8]) begin
					credit_d = pend_d[7:0];
				end
				pend_d = '0;
				phase_d = PH_TYPE;
			end
			res.end_of_packet = finish;
		end
		res.credits_now = credit_d;
	end

	// Parser state and credit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			kind_q   <= 1'b0;
			evcode_q <= '0;
			len_lo_q <= '0;
			remain_q <= '0;
			count_q  <= '0;
			credit_q <= CREDITS_RESET;
			pend_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			credit_q <= cfg_data;
		end else if (in_fire) begin
			phase_q  <= phase_d;
			kind_q   <= kind_d;
			evcode_q <= evcode_d;
			len_lo_q <= len_lo_d;
			remain_q <= remain_d;
			count_q  <= count_d;
			credit_q <= credit_d;
			pend_q   <= pend_d;
		end
	end

	// Output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				if (!out_valid_q || m_axis_tready) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	// Result payloads need no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (!out_valid_q || m_axis_tready) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (out_fire && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_q.end_of_packet;
	assign m_axis_tuser  = {out_q.packet_kind, out_q.byte_class};
	assign m_axis_tdata  = {6'd0, out_q.command_granted, out_q.credits_now, out_q.bad_type,
		out_q.payload_index, out_q.data_byte};

`ifndef ASSERT_OFF
	// The skid entry is only used while the output register is full
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a beat while output register is empty");

	// A granted command never carries a parsed byte
	a_grant_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[33]) |->
		(m_axis_tuser[3:0] == CLS_NONE && !m_axis_tlast))
		else $error("granted command beat carries a byte class");

	// A bad type byte is always reported as a type byte of no packet
	a_bad_is_type: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[24]) |->
		(m_axis_tuser[3:0] == CLS_TYPE && m_axis_tuser[5:4] == KIND_NONE))
		else $error("bad type flag on a beat that is not an unknown type byte");

	// A command request with credits left consumes exactly one
	a_grant_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !cfg_valid && s_axis_tuser == REQ_CMD && credit_q != 8'd0) |=>
		(credit_q == $past(credit_q) - 8'd1))
		else $error("command grant did not consume one credit");

	// Packets end only when the parser returns to the type phase
	a_eop_to_type: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !cfg_valid && res.end_of_packet) |=> (phase_q == PH_TYPE))
		else $error("packet ended without returning to the type phase");
`endif

endmodule

`default_nettype wire

// ===== verif/hci_uart_rx_deframer_credits_top_tb.sv =====
// Self-checking testbench for the HCI UART (H4) receive deframer with credit tracking.
// It needs hcirx_pkg and hci_uart_rx_deframer_credits_top from the design folder.
// A queue-fed stream driver, a result monitor and a built-in H4 parser predict each beat.
`default_nettype none

module hci_uart_rx_deframer_credits_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hcirx_pkg::*;

	// Cycles with work outstanding but no beat moving before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	localparam int NUM_PHASES  = 6;

	// Parser phases of the H4 byte stream
	typedef enum logic [2:0] {
		PH_TYPE, PH_EVCODE, PH_EVLEN, PH_PAYLOAD, PH_HLO, PH_HHI, PH_LLO, PH_LHI
	} h4_phase_t;

	// One pending input beat: request kind and received byte
	typedef struct packed {
		logic       req;
		logic [7:0] val;
	} uart_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
	logic        s_axis_tuser = 1'b0; // [0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [7:0] data_byte, [23:8] payload_index, [24] bad_type, [32:25] credits_now,
	// [33] command_granted, [39:34] zero
	logic [TDATA_W-1:0] m_axis_tdata;
	logic [TUSER_W-1:0] m_axis_tuser; // [3:0] byte_class, [5:4] packet_kind
	logic        m_axis_tlast;        // end_of_packet

	hci_uart_rx_deframer_credits_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #6 clk = ~clk;

	// Stimulus and expected results
	uart_item_t uart_feed_q[$];
	res_t       beat_reports_q[$];
	int         fed_total = 0;
	bit         mix_cmds = 1'b0;
	bit         in_steady = 1'b0;
	bit         out_steady = 1'b0;
	int         send_gap = 0;
	int         recv_stall = 0;
	int         idle_cycles = 0;

	// Statistics and errors
	int fail_count = 0;
	int pkt_ends = 0;
	int grants = 0;
	int refusals = 0;
	int bad_types = 0;
	int credit_loads = 0;
	int top_index = 0;

	// Predicted parser and credit state
	h4_phase_t   rx_phase;
	logic        acl_mode;
	logic [7:0]  held_code;
	logic [7:0]  held_len_lo;
	logic [15:0] bytes_left;
	logic [15:0] param_idx;
	logic [7:0]  credit_pred;
	logic [8:0]  pend_load;

	function automatic void reset_prediction();
		rx_phase    = PH_TYPE;
		acl_mode    = 1'b0;
		held_code   = '0;
		held_len_lo = '0;
		bytes_left  = '0;
		param_idx   = '0;
		credit_pred = CREDITS_RESET;
		pend_load   = '0;
	endfunction

	// A packet ends: a latched credit value takes effect, the parser waits for a type.
	function automatic void close_packet();
		if (pend_load[8]) begin
			credit_pred = pend_load[7:0];
		end
		pend_load = '0;
		rx_phase  = PH_TYPE;
	endfunction

	// Classify one accepted input beat and advance the predicted state.
	function automatic res_t classify_beat(logic req, logic [7:0] b);
		res_t r;
		r = '0;
		r.byte_class  = CLS_NONE;
		r.packet_kind = KIND_NONE;
		if (req == REQ_CMD) begin
			if (credit_pred != 8'd0) begin
				credit_pred = credit_pred - 8'd1;
				r.command_granted = 1'b1;
			end
		end else begin
			r.data_byte = b;
			case (rx_phase)
				PH_TYPE: begin
					r.byte_class = CLS_TYPE;
					pend_load = '0;
					if (b == CODE_EVENT) begin
						acl_mode = 1'b0;
						r.packet_kind = KIND_EVENT;
						rx_phase = PH_EVCODE;
					end else if (b == CODE_ACL) begin
						acl_mode = 1'b1;
						r.packet_kind = KIND_ACL;
						rx_phase = PH_HLO;
					end else begin
						r.bad_type = 1'b1;
					end
				end
				PH_EVCODE: begin
					r.byte_class = CLS_EVCODE;
					r.packet_kind = KIND_EVENT;
					held_code = b;
					rx_phase = PH_EVLEN;
				end
				PH_EVLEN: begin
					r.byte_class = CLS_EVLEN;
					r.packet_kind = KIND_EVENT;
					bytes_left = {8'd0, b};
					param_idx = '0;
					if (b == 8'd0) begin
						r.end_of_packet = 1'b1;
						close_packet();
					end else begin
						rx_phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					r.packet_kind = acl_mode ? KIND_ACL : KIND_EVENT;
					r.byte_class = acl_mode ? CLS_ACLDATA : CLS_EVPARAM;
					r.payload_index = param_idx;
					// Credit count sits in parameter 0 of Command Complete and
					// parameter 1 of Command Status.
					if (!acl_mode && ((held_code == EV_CMD_COMPLETE && param_idx == 16'd0) ||
						(held_code == EV_CMD_STATUS && param_idx == 16'd1))) begin
						pend_load = {1'b1, b};
					end
					param_idx = param_idx + 16'd1;
					if (bytes_left <= 16'd1) begin
						bytes_left = '0;
						r.end_of_packet = 1'b1;
						close_packet();
					end else begin
						bytes_left = bytes_left - 16'd1;
					end
				end
				PH_HLO: begin
					r.byte_class = CLS_HLO;
					r.packet_kind = KIND_ACL;
					rx_phase = PH_HHI;
				end
				PH_HHI: begin
					r.byte_class = CLS_HHI;
					r.packet_kind = KIND_ACL;
					rx_phase = PH_LLO;
				end
				PH_LLO: begin
					r.byte_class = CLS_LLO;
					r.packet_kind = KIND_ACL;
					held_len_lo = b;
					rx_phase = PH_LHI;
				end
				default: begin
					r.byte_class = CLS_LHI;
					r.packet_kind = KIND_ACL;
					bytes_left = {b, held_len_lo};
					param_idx = '0;
					if (bytes_left == 16'd0) begin
						r.end_of_packet = 1'b1;
						close_packet();
					end else begin
						rx_phase = PH_PAYLOAD;
					end
				end
			endcase
		end
		r.credits_now = credit_pred;
		return r;
	endfunction

	// Names of the fields that differ between the expected and the observed beat.
	function automatic string diff_fields(res_t w, res_t g);
		string s;
		s = "";
		if (g.byte_class !== w.byte_class) s = {s, " byte_class"};
		if (g.packet_kind !== w.packet_kind) s = {s, " packet_kind"};
		if (g.data_byte !== w.data_byte) s = {s, " data_byte"};
		if (g.payload_index !== w.payload_index) s = {s, " payload_index"};
		if (g.end_of_packet !== w.end_of_packet) s = {s, " end_of_packet"};
		if (g.bad_type !== w.bad_type) s = {s, " bad_type"};
		if (g.credits_now !== w.credits_now) s = {s, " credits_now"};
		if (g.command_granted !== w.command_granted) s = {s, " command_granted"};
		return s;
	endfunction

	// Stream driver: presents queued beats, with a random gap after each one unless in_steady is set.
	always @(posedge clk or negedge arst_n) begin : uart_driver
		uart_item_t it;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= REQ_BYTE;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				beat_reports_q.push_back(classify_beat(s_axis_tuser, s_axis_tdata));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (uart_feed_q.size() != 0) begin
					it = uart_feed_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= it.val;
					s_axis_tuser  <= it.req;
					send_gap <= in_steady ? 0 : $urandom_range(0, 5);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each beat against the oldest expectation and, unless
	// out_steady is set, holds tready low for a random stall after each one.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		int   hold_n;
		res_t got;
		res_t want;
		string bad_fields;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall    <= 0;
		end else begin
			hold_n = recv_stall;
			if (m_axis_tvalid && m_axis_tready) begin
				got.data_byte       = m_axis_tdata[7:0];
				got.payload_index   = m_axis_tdata[23:8];
				got.bad_type        = m_axis_tdata[24];
				got.credits_now     = m_axis_tdata[32:25];
				got.command_granted = m_axis_tdata[33];
				got.byte_class      = m_axis_tuser[3:0];
				got.packet_kind     = m_axis_tuser[5:4];
				got.end_of_packet   = m_axis_tlast;
				if (beat_reports_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: unexpected result beat class=%0d kind=%0d data=%02h",
							$realtime, got.byte_class, got.packet_kind, got.data_byte);
					end
				end else begin
					want = beat_reports_q.pop_front();
					bad_fields = diff_fields(want, got);
					if (bad_fields != "") begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch in%s", $realtime, bad_fields);
							$display("  expected cls=%0d kind=%0d data=%02h idx=%0d eop=%b bad=%b cr=%0d gr=%b",
								want.byte_class, want.packet_kind, want.data_byte,
								want.payload_index, want.end_of_packet, want.bad_type,
								want.credits_now, want.command_granted);
							$display("  actual   cls=%0d kind=%0d data=%02h idx=%0d eop=%b bad=%b cr=%0d gr=%b",
								got.byte_class, got.packet_kind, got.data_byte,
								got.payload_index, got.end_of_packet, got.bad_type,
								got.credits_now, got.command_granted);
						end
					end
				end
				if (got.end_of_packet) pkt_ends++;
				if (got.bad_type) bad_types++;
				if (got.command_granted) grants++;
				if (got.byte_class == CLS_NONE && !got.command_granted) refusals++;
				if (got.payload_index > top_index) top_index = got.payload_index;
				hold_n = out_steady ? 0 : $urandom_range(0, 5);
			end
			if (hold_n != 0) begin
				m_axis_tready <= 1'b0;
				recv_stall <= hold_n - 1;
			end else begin
				m_axis_tready <= 1'b1;
				recv_stall <= 0;
			end
		end
	end

	// Watchdog: counts cycles in which work is owed but no beat moves.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready) ||
			(uart_feed_q.size() == 0 && beat_reports_q.size() == 0 && !cfg_valid)) begin
			idle_cycles <= 0;
		end else if (idle_cycles < STALL_LIMIT) begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_item(input logic req, input logic [7:0] v);
		uart_item_t it;
		it.req = req;
		it.val = v;
		uart_feed_q.push_back(it);
		fed_total++;
	endtask

	// A received byte, sometimes preceded by a command request mid-stream.
	task automatic push_rx(input logic [7:0] v);
		if (mix_cmds && $urandom_range(0, 19) == 0) begin
			push_item(REQ_CMD, 8'($urandom));
		end
		push_item(REQ_BYTE, v);
	endtask

	task automatic push_event(input logic [7:0] code, input logic [7:0] len,
		input logic [7:0] credit_val);
		push_rx(CODE_EVENT);
		push_rx(code);
		push_rx(len);
		for (int i = 0; i < len; i++) begin
			if ((code == EV_CMD_COMPLETE && i == 0) || (code == EV_CMD_STATUS && i == 1)) begin
				push_rx(credit_val);
			end else begin
				push_rx(8'($urandom));
			end
		end
	endtask

	task automatic push_acl(input logic [15:0] len);
		push_rx(CODE_ACL);
		push_rx(8'($urandom));
		push_rx(8'($urandom));
		push_rx(len[7:0]);
		push_rx(len[15:8]);
		for (int i = 0; i < len; i++) begin
			push_rx(8'($urandom));
		end
	endtask

	function automatic logic [7:0] pick_credit();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly well-formed packets with random content, plus command bursts,
	// stray bytes and packets cut short.
	task automatic random_traffic(input int n);
		int stop_at;
		int sel;
		logic [7:0] code;
		stop_at = fed_total + n;
		while (fed_total < stop_at) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				case ($urandom_range(0, 2))
					0: code = EV_CMD_COMPLETE;
					1: code = EV_CMD_STATUS;
					default: code = 8'($urandom);
				endcase
				push_event(code,
					($urandom_range(0, 9) == 0) ? 8'($urandom_range(6, 40)) :
						8'($urandom_range(0, 5)),
					pick_credit());
			end else if (sel < 65) begin
				push_acl(($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 30)) :
					16'($urandom_range(0, 8)));
			end else if (sel < 80) begin
				repeat ($urandom_range(1, 4)) push_item(REQ_CMD, 8'($urandom));
			end else if (sel < 90) begin
				repeat ($urandom_range(1, 3)) push_rx(8'($urandom));
			end else begin
				// Header only, so the next packet's bytes land mid-parse
				push_rx(($urandom_range(0, 1) == 0) ? CODE_EVENT : CODE_ACL);
				repeat ($urandom_range(0, 3)) push_rx(8'($urandom));
			end
		end
	endtask

	// Wait until every queued beat is sent and every result has come back, or the watchdog trips.
	// The bench must look quiet at successive edges, so a beat that the
	// driver picks up at the same edge as a check is never missed.
	task automatic drain_all();
		int quiet;
		quiet = 0;
		while (quiet < 2 && idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (uart_feed_q.size() == 0 && !s_axis_tvalid && beat_reports_q.size() == 0) begin
				quiet++;
			end else begin
				quiet = 0;
			end
		end
	endtask

	// Write initial_credits; the credit count is loaded at the same edge.
	task automatic write_credits(input logic [7:0] v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!(cfg_valid && cfg_ready) && idle_cycles < STALL_LIMIT);
		if (cfg_valid && cfg_ready) begin
			credit_pred = v;
		end
		cfg_valid <= 1'b0;
	endtask

	// Main sequence: reset, directed cases, then random phases at several settings
	initial begin : main_seq
		logic [7:0] credit_plan [NUM_PHASES];
		credit_plan = '{8'd0, 8'hFF, 8'd1, 8'd0, 8'd0, 8'd3};
		credit_plan[3] = 8'($urandom);
		credit_plan[4] = 8'($urandom_range(2, 20));
		reset_prediction();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: credits from reset, refusal at zero, unknown types,
		// zero-length packets, short and full credit events.
		push_item(REQ_CMD, 8'h00);
		push_item(REQ_CMD, 8'hFF);
		push_item(REQ_BYTE, 8'hFF);
		push_item(REQ_BYTE, 8'h00);
		push_event(EV_CMD_COMPLETE, 8'd0, 8'd0);
		push_event(EV_CMD_COMPLETE, 8'd1, 8'd5);
		push_event(EV_CMD_STATUS, 8'd1, 8'd0);
		push_event(EV_CMD_STATUS, 8'd2, 8'hFF);
		push_acl(16'd0);
		push_acl(16'd1);
		push_item(REQ_CMD, 8'h5A);
		drain_all();

		// Random phases; the sender waits for all results before each write.
		mix_cmds = 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			in_steady  = (p == 1 || p == 3);
			out_steady = (p == 1 || p == 4);
			write_credits(credit_plan[p]);
			if (p == 2) begin
				push_acl({8'h01, 8'($urandom)});
			end
			random_traffic(150);
			drain_all();
		end

		// Let any stray beat show up before the verdict
		repeat (10) @(posedge clk);
		if (idle_cycles >= STALL_LIMIT) begin
			fail_count++;
			$display("no progress for %0d cycles, %0d results outstanding",
				STALL_LIMIT, beat_reports_q.size());
		end else if (beat_reports_q.size() != 0) begin
			fail_count++;
			$display("%0d expected results never arrived", beat_reports_q.size());
		end
		$display("Sent %0d beats over %0d credit settings; %0d packets closed, %0d bad types.",
			fed_total, NUM_PHASES + 1, pkt_ends, bad_types);
		$display("Commands: %0d granted, %0d refused; highest payload index %0d; %0d errors.",
			grants, refusals, top_index, fail_count);
		if (fail_count == 0) begin
			$display("hci_uart_rx_deframer_credits_top verification clean");
		end else begin
			$display("hci_uart_rx_deframer_credits_top verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
